// ===== hdl/subs_pkg.sv =====
package subs_pkg;

	localparam int OutcomeW = 3;
	localparam int KeyW     = 4;
	localparam int SenseW   = 8;
	localparam int CmdW     = 4;
	localparam int StatusW  = 2;
	localparam int PosW     = 5;
	localparam int CfgIdxW  = 2;
	localparam int InDataW  = 24;
	localparam int OutDataW = 16;

	// sequencer positions
	typedef enum logic [PosW-1:0] {
		P_INQ           = 5'd0,
		P_INQ_SENSE     = 5'd1,
		P_NOT_READY     = 5'd2,
		P_NR_SENSE      = 5'd3,
		P_START         = 5'd4,
		P_START_SENSE   = 5'd5,
		P_PREVENT       = 5'd6,
		P_PREVENT_SENSE = 5'd7,
		P_READ_CAP      = 5'd8,
		P_MS10          = 5'd9,
		P_MS10_SENSE    = 5'd10,
		P_MS6           = 5'd11,
		P_MS6_SENSE     = 5'd12,
		P_CONNECTED     = 5'd13,
		P_STATUS_CHECK  = 5'd14,
		P_ALLOW         = 5'd15,
		P_STOP          = 5'd16,
		P_SENSE         = 5'd17
	} pos_t;

	typedef enum logic [CmdW-1:0] {
		CMD_INQUIRY  = 4'd0,
		CMD_SENSE    = 4'd1,
		CMD_TUR      = 4'd2,
		CMD_START    = 4'd3,
		CMD_STOP     = 4'd4,
		CMD_PREVENT  = 4'd5,
		CMD_ALLOW    = 4'd6,
		CMD_READCAP  = 4'd7,
		CMD_MS10     = 4'd8,
		CMD_MS6      = 4'd9,
		CMD_NONE     = 4'd10
	} cmd_t;

	typedef enum logic [StatusW-1:0] {
		ST_CONT   = 2'd0,
		ST_DONE   = 2'd1,
		ST_NOTSUP = 2'd2,
		ST_FATAL  = 2'd3
	} status_t;

	// transport outcome codes
	localparam logic [OutcomeW-1:0] OC_GOOD   = 3'd0;
	localparam logic [OutcomeW-1:0] OC_FAILED = 3'd1;
	localparam logic [OutcomeW-1:0] OC_PHASE  = 3'd2;
	localparam logic [OutcomeW-1:0] OC_NOTSUP = 3'd3;

	// sense codes of interest
	localparam logic [KeyW-1:0]   KEY_NOT_READY   = 4'd2;
	localparam logic [KeyW-1:0]   KEY_ILLEGAL_REQ = 4'd5;
	localparam logic [KeyW-1:0]   KEY_UNIT_ATTN   = 4'd6;
	localparam logic [SenseW-1:0] ASC_NOT_READY   = 8'h04;
	localparam logic [SenseW-1:0] ASCQ_INIT_REQD  = 8'h02;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_REMOVABLE   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_BLOCK_CMDS  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_STATUS_POLL = 2'd2;

	typedef struct packed {
		logic removable_media;
		logic block_commands_supported;
		logic status_check_enable;
	} cfg_t;

	typedef struct packed {
		pos_t    np;
		status_t st;
		logic    set_ssr;
	} step_res_t;

	function automatic cmd_t cmd_of(input pos_t p);
		cmd_t c;
		case (p)
			P_INQ:          c = CMD_INQUIRY;
			P_NOT_READY:    c = CMD_TUR;
			P_START:        c = CMD_START;
			P_PREVENT:      c = CMD_PREVENT;
			P_READ_CAP:     c = CMD_READCAP;
			P_MS10:         c = CMD_MS10;
			P_MS6:          c = CMD_MS6;
			P_CONNECTED:    c = CMD_NONE;
			P_STATUS_CHECK: c = CMD_TUR;
			P_ALLOW:        c = CMD_ALLOW;
			P_STOP:         c = CMD_STOP;
			default:        c = CMD_SENSE;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/subs_step.sv =====
module subs_step (
	input  subs_pkg::pos_t                     pos,
	input  logic [subs_pkg::OutcomeW-1:0]      outcome,
	input  logic [subs_pkg::KeyW-1:0]          sense_key,
	input  logic [subs_pkg::SenseW-1:0]        sense_asc,
	input  logic [subs_pkg::SenseW-1:0]        sense_ascq,
	input  subs_pkg::cfg_t                     cfg,
	input  logic                               ssr,
	output subs_pkg::step_res_t                res,
	output subs_pkg::cmd_t                     next_command,
	output logic                               connected
);
	import subs_pkg::*;

	typedef enum logic [2:0] {EV_PASS, EV_FAIL, EV_ERR, EV_NOTSUP, EV_FATAL} ev_t;

	ev_t  ev;
	cmd_t cur_cmd;
	logic ok, err, after_cap, pos_valid;
	pos_t sense_np;
	status_t sense_st;

	assign cur_cmd   = cmd_of(pos);
	assign pos_valid = (pos <= P_SENSE);
	assign after_cap = cfg.removable_media;
	assign ok        = (ev == EV_PASS);
	assign err       = (ev == EV_ERR);

	// outcome mapping per issued command
	always_comb begin
		case (cur_cmd)
			CMD_NONE: ev = EV_PASS;
			CMD_INQUIRY: begin
				if (outcome == OC_GOOD)        ev = EV_PASS;
				else if (outcome == OC_FAILED) ev = EV_FAIL;
				else if (outcome == OC_NOTSUP) ev = EV_NOTSUP;
				else                           ev = EV_FATAL;
			end
			CMD_SENSE: begin
				if (outcome == OC_GOOD)        ev = EV_PASS;
				else if (outcome == OC_FAILED) ev = EV_NOTSUP;
				else                           ev = EV_FATAL;
			end
			CMD_READCAP, CMD_MS10, CMD_MS6: begin
				if (outcome == OC_GOOD)        ev = EV_PASS;
				else if (outcome == OC_FAILED) ev = EV_FAIL;
				else if (outcome == OC_PHASE)  ev = EV_ERR;
				else if (outcome == OC_NOTSUP) ev = EV_NOTSUP;
				else                           ev = EV_FATAL;
			end
			default: ev = (outcome == OC_GOOD) ? EV_PASS : EV_FAIL;
		endcase
	end

	// unit attention restarts, anything else gives up at not ready
	assign sense_np = (sense_key == KEY_UNIT_ATTN) ? P_INQ : P_NOT_READY;
	assign sense_st = (sense_key == KEY_UNIT_ATTN) ? ST_CONT : ST_DONE;

	// next state
	always_comb begin
		res.np      = pos;
		res.st      = ST_CONT;
		res.set_ssr = 1'b0;
		if (!pos_valid) begin
			res.np = P_INQ;
		end else if (ev == EV_NOTSUP) begin
			res.st = ST_NOTSUP;
		end else if (ev == EV_FATAL) begin
			res.st = ST_FATAL;
		end else begin
			case (pos)
				P_INQ: res.np = ok ? P_NOT_READY : P_INQ_SENSE;
				P_INQ_SENSE: begin
					res.np = P_INQ;
					res.st = ST_DONE;
				end
				P_NOT_READY: begin
					if (ok)
						res.np = (cfg.block_commands_supported && after_cap) ?
						         P_PREVENT : P_READ_CAP;
					else
						res.np = P_NR_SENSE;
				end
				P_NR_SENSE: begin
					if (sense_key == KEY_NOT_READY && sense_asc == ASC_NOT_READY &&
					    sense_ascq == ASCQ_INIT_REQD) begin
						res.set_ssr = 1'b1;
						res.np      = P_START;
					end else begin
						res.np = sense_np;
						res.st = sense_st;
					end
				end
				P_START: begin
					if (ok) res.np = after_cap ? P_PREVENT : P_READ_CAP;
					else    res.np = P_START_SENSE;
				end
				P_START_SENSE:   res.np = after_cap ? P_PREVENT : P_READ_CAP;
				P_PREVENT:       res.np = ok ? P_READ_CAP : P_PREVENT_SENSE;
				P_PREVENT_SENSE: res.np = P_READ_CAP;
				P_READ_CAP: begin
					if (ok) begin
						res.np = P_MS10;
					end else begin
						res.np = err ? P_NOT_READY : P_SENSE;
						res.st = ST_DONE;
					end
				end
				P_MS10: begin
					if (ok) begin
						res.np = P_CONNECTED;
						res.st = ST_DONE;
					end else begin
						res.np = err ? P_MS6 : P_MS10_SENSE;
					end
				end
				P_MS10_SENSE: begin
					if (sense_key == KEY_ILLEGAL_REQ) begin
						res.np = P_MS6;
					end else begin
						res.np = sense_np;
						res.st = sense_st;
					end
				end
				P_MS6: begin
					if (ok || err) begin
						res.np = P_CONNECTED;
						res.st = ST_DONE;
					end else begin
						res.np = P_MS6_SENSE;
					end
				end
				P_MS6_SENSE: begin
					if (sense_key == KEY_ILLEGAL_REQ) begin
						res.np = P_CONNECTED;
						res.st = ST_DONE;
					end else begin
						res.np = sense_np;
						res.st = sense_st;
					end
				end
				P_CONNECTED: begin
					if (after_cap) begin
						res.np = cfg.status_check_enable ? P_STATUS_CHECK : P_ALLOW;
					end else if (ssr) begin
						res.np = P_STOP;
					end else begin
						res.np = P_NOT_READY;
						res.st = ST_DONE;
					end
				end
				P_STATUS_CHECK: begin
					if (ok) begin
						res.np = P_CONNECTED;
						res.st = ST_DONE;
					end else begin
						res.np = P_SENSE;
					end
				end
				P_ALLOW: begin
					if (!ok) begin
						res.np = P_INQ;
						res.st = ST_DONE;
					end else if (ssr) begin
						res.np = P_STOP;
					end else begin
						res.np = P_NOT_READY;
						res.st = ST_DONE;
					end
				end
				P_STOP: begin
					res.np = ok ? P_NOT_READY : P_INQ;
					res.st = ST_DONE;
				end
				default: begin
					res.np = P_NOT_READY;
					res.st = ST_DONE;
				end
			endcase
		end
	end

	// outputs of the new position
	always_comb begin
		next_command = cmd_of(res.np);
		connected    = (res.np == P_CONNECTED);
	end

endmodule

// ===== hdl/scsi_unit_bringup_sequencer.sv =====
// Channel  | Dir | Handshake          | Contents
// ---------+-----+--------------------+-------------------------------------------
// s_*      | in  | s_tvalid/s_tready  | one command outcome plus last sense data
// m_*      | out | m_tvalid/m_tready  | next command, status, connected, position
// cfg_*    | in  | cfg_wr_en          | removable, block cmds, status poll (1b each)
//
// One item per cycle sustained while m_tready is high. An accepted item waits in the
// input register while the position register drives a short next-state decode; the
// result enters the output register, raising m_tvalid, when it is free. Position updates
// as the result is stored, so the following item sees it at once. arst_n clears position
// to inquiry, the start/stop-required flag and the config bits. A stall on m_tready holds
// the result; the input register takes one more item, then s_tready drops until it moves.
module scsi_unit_bringup_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [2:0] outcome, [6:3] sense_key, [14:7] sense_asc, [22:15] sense_ascq
	input  logic [subs_pkg::InDataW-1:0]        s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [3:0] next_command, [5:4] step_status, [6] connected, [11:7] position
	output logic [subs_pkg::OutDataW-1:0]       m_tdata,
	input  logic                                cfg_wr_en,
	input  logic [subs_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic                                cfg_data
);
	import subs_pkg::*;

	// input stage
	logic                  v_s1;
	logic [OutcomeW-1:0]   outcome_s1;
	logic [KeyW-1:0]       key_s1;
	logic [SenseW-1:0]     asc_s1;
	logic [SenseW-1:0]     ascq_s1;

	// result stage
	logic                  v_s2;
	cmd_t                  cmd_s2;
	status_t               st_s2;
	logic                  conn_s2;
	pos_t                  pos_s2;

	// sequencer state and config
	pos_t                  pos_q;
	logic                  ssr_q;
	cfg_t                  cfg_q;

	step_res_t             res;
	cmd_t                  nxt_cmd;
	logic                  nxt_conn;
	logic                  adv_s1, take_s0;

	assign adv_s1   = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv_s1;
	assign take_s0  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_REMOVABLE:   cfg_q.removable_media          <= cfg_data;
				REG_BLOCK_CMDS:  cfg_q.block_commands_supported <= cfg_data;
				REG_STATUS_POLL: cfg_q.status_check_enable      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s0) begin
			outcome_s1 <= s_tdata[2:0];
			key_s1     <= s_tdata[6:3];
			asc_s1     <= s_tdata[14:7];
			ascq_s1    <= s_tdata[22:15];
		end
	end

	subs_step u_step (
		.pos          (pos_q),
		.outcome      (outcome_s1),
		.sense_key    (key_s1),
		.sense_asc    (asc_s1),
		.sense_ascq   (ascq_s1),
		.cfg          (cfg_q),
		.ssr          (ssr_q),
		.res          (res),
		.next_command (nxt_cmd),
		.connected    (nxt_conn)
	);

	// state commits when the result is stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= P_INQ;
			ssr_q <= 1'b0;
		end else if (adv_s1) begin
			pos_q <= res.np;
			if (res.set_ssr)
				ssr_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || m_tready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s2  <= nxt_cmd;
			st_s2   <= res.st;
			conn_s2 <= nxt_conn;
			pos_s2  <= res.np;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {4'b0000, pos_s2, conn_s2, st_s2, cmd_s2};

endmodule
